@@ design/sg2d_pkg.sv @@
`default_nettype none
package sg2d_pkg;

  // Grid limits
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  // Counter widths follow the grid limits
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);

  // Field widths
  localparam int DIM_W    = 11;
  localparam int INV_W    = 24;
  localparam int SAMPLE_W = 24;
  localparam int VALUE_W  = 32;
  localparam int INDEX_W  = 20;
  localparam int FRAC_W   = 16;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_WIDTH  = 2'd0,
    REG_GRID_HEIGHT = 2'd1,
    REG_INV_STEP_X  = 2'd2,
    REG_INV_STEP_Y  = 2'd3
  } cfg_reg_t;

  localparam int DIFF_W = SAMPLE_W + 1;
  localparam int PROD_W = DIFF_W + INV_W + 1;

  // Per-direction data carried down the pipeline
  typedef struct packed {
    logic                       valid;
    logic signed [DIFF_W-1:0]   diff;
    logic [INDEX_W-1:0]         index;
  } grad_meta_t;

endpackage
`default_nettype wire

@@ design/sg2d_if.sv @@
`default_nettype none
interface sg2d_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [sg2d_pkg::SAMPLE_W-1:0]  sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface sg2d_out_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  gx_valid;
  logic signed [sg2d_pkg::VALUE_W-1:0]   gx_value;
  logic [sg2d_pkg::INDEX_W-1:0]          gx_index;
  logic                                  gy_valid;
  logic signed [sg2d_pkg::VALUE_W-1:0]   gy_value;
  logic [sg2d_pkg::INDEX_W-1:0]          gy_index;
  logic                                  frame_end;

  modport source (output valid, output gx_valid, output gx_value, output gx_index,
                  output gy_valid, output gy_value, output gy_index, output frame_end,
                  input ready);
  modport sink   (input valid, input gx_valid, input gx_value, input gx_index,
                  input gy_valid, input gy_value, input gy_index, input frame_end,
                  output ready);
endinterface
`default_nettype wire

@@ design/staggered_gradient_2d_top.sv @@
// A result passes through the stage 1, stage 2 and output registers to out_ch; a stall on out_ch holds it.
// Throughput: one item per cycle while out_ch does not stall; the row store does one read and one write per item.
// Items that complete no difference and do not end the frame give no result.
// Reset (rst_n low, synchronous): counters to frame start, pipeline emptied,
// registers to width 1024, height 1024, reciprocals 1.0. Row store is not cleared.
`default_nettype none
module staggered_gradient_2d_top (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  sg2d_in_if.sink                                  in_ch,
  sg2d_out_if.source                               out_ch,
  input  wire logic                                cfg_we,
  input  wire logic [sg2d_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [sg2d_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int COL_W   = sg2d_pkg::COL_W;
  localparam int ROW_W   = sg2d_pkg::ROW_W;
  localparam int DIM_W   = sg2d_pkg::DIM_W;
  localparam int INV_W   = sg2d_pkg::INV_W;
  localparam int SMP_W   = sg2d_pkg::SAMPLE_W;
  localparam int IDX_W   = sg2d_pkg::INDEX_W;
  localparam int VAL_W   = sg2d_pkg::VALUE_W;
  localparam int PROD_W  = sg2d_pkg::PROD_W;
  localparam int FRAC_W  = sg2d_pkg::FRAC_W;
  localparam int Q_W     = PROD_W - FRAC_W;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [DIM_W-1:0] grid_width_r, grid_height_r;
  logic [INV_W-1:0] inv_step_x_r, inv_step_y_r;
  logic             geom_wr;

  assign geom_wr = cfg_we && (cfg_index == sg2d_pkg::REG_GRID_WIDTH ||
                              cfg_index == sg2d_pkg::REG_GRID_HEIGHT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= DIM_W'(1024);
      grid_height_r <= DIM_W'(1024);
      inv_step_x_r  <= INV_W'(65536);
      inv_step_y_r  <= INV_W'(65536);
    end else if (cfg_we) begin
      case (sg2d_pkg::cfg_reg_t'(cfg_index))
        sg2d_pkg::REG_GRID_WIDTH:  grid_width_r  <= cfg_data[DIM_W-1:0];
        sg2d_pkg::REG_GRID_HEIGHT: grid_height_r <= cfg_data[DIM_W-1:0];
        sg2d_pkg::REG_INV_STEP_X:  inv_step_x_r  <= cfg_data[INV_W-1:0];
        sg2d_pkg::REG_INV_STEP_Y:  inv_step_y_r  <= cfg_data[INV_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective geometry: zero acts as one, oversize is clipped to the limit
  logic [DIM_W-1:0] w_eff, h_eff;
  logic [COL_W-1:0] col_last;
  logic [ROW_W-1:0] row_last;

  always_comb begin
    if (grid_width_r == '0)                            w_eff = DIM_W'(1);
    else if (int'(grid_width_r) > sg2d_pkg::MAX_WIDTH) w_eff = DIM_W'(sg2d_pkg::MAX_WIDTH);
    else                                               w_eff = grid_width_r;
    if (grid_height_r == '0)                             h_eff = DIM_W'(1);
    else if (int'(grid_height_r) > sg2d_pkg::MAX_HEIGHT) h_eff = DIM_W'(sg2d_pkg::MAX_HEIGHT);
    else                                                 h_eff = grid_height_r;
  end

  assign col_last = COL_W'(w_eff - DIM_W'(1));
  assign row_last = ROW_W'(h_eff - DIM_W'(1));

  // ---------------------------------------------------------------------------
  // Pipeline handshake: s1 (store read) -> s2 (products) -> output register
  // ---------------------------------------------------------------------------
  logic s1_v_r, s2_v_r, out_v_r;
  logic out_free, s2_free, s1_free, accept;

  assign out_free    = !out_v_r || out_ch.ready;
  assign s2_free     = !s2_v_r || out_free;
  assign s1_free     = !s1_v_r || s2_free;
  assign in_ch.ready = s1_free;
  assign accept      = in_ch.valid && s1_free;

  // ---------------------------------------------------------------------------
  // Stage 0: raster position, indices, counter update
  // ---------------------------------------------------------------------------
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  // xbase = (w-1)*row, ybase = w*(row-1); kept as running sums, no multiplier
  logic [IDX_W-1:0] xbase_r, xbase_nxt, ybase_r, ybase_nxt;
  logic             fend, has_res, gxv, gyv;
  logic [IDX_W-1:0] gxi, gyi;

  assign gxv     = (col_r != '0);
  assign gyv     = (row_r != '0);
  assign fend    = (col_r == col_last) && (row_r == row_last);
  assign has_res = gxv || gyv || fend;
  assign gxi     = gxv ? IDX_W'(col_r - COL_W'(1)) + xbase_r : '0;
  assign gyi     = gyv ? IDX_W'(col_r) + ybase_r : '0;

  always_comb begin
    col_nxt   = col_r;
    row_nxt   = row_r;
    xbase_nxt = xbase_r;
    ybase_nxt = ybase_r;
    if (geom_wr) begin
      // geometry change restarts the frame
      col_nxt   = '0;
      row_nxt   = '0;
      xbase_nxt = '0;
      ybase_nxt = '0;
    end else if (accept) begin
      if (fend) begin
        col_nxt   = '0;
        row_nxt   = '0;
        xbase_nxt = '0;
        ybase_nxt = '0;
      end else if (col_r == col_last) begin
        col_nxt   = '0;
        row_nxt   = row_r + ROW_W'(1);
        xbase_nxt = xbase_r + IDX_W'(col_last);
        if (row_r != '0) ybase_nxt = ybase_r + IDX_W'(w_eff);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      xbase_r <= '0;
      ybase_r <= '0;
    end else begin
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      xbase_r <= xbase_nxt;
      ybase_r <= ybase_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Row store: one write and one read per item, read-first. Consecutive items
  // touch the same column only when the width is one, and then the write of
  // the earlier item has landed before the later one reads.
  // ---------------------------------------------------------------------------
  logic signed [SMP_W-1:0] row_mem [sg2d_pkg::MAX_WIDTH];
  logic signed [SMP_W-1:0] above_r;
  logic signed [SMP_W-1:0] left_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      row_mem[col_r] <= in_ch.sample;
      above_r        <= row_mem[col_r];
      left_r         <= in_ch.sample;
    end
  end

  // Stage 1 registers (above_r is the store's read register)
  logic signed [SMP_W-1:0] s1_sample_r, s1_left_r;
  logic                    s1_gxv_r, s1_gyv_r, s1_fend_r;
  logic [IDX_W-1:0]        s1_gxi_r, s1_gyi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_free) begin
      s1_v_r <= accept && has_res;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_sample_r <= in_ch.sample;
      s1_left_r   <= left_r;
      s1_gxv_r    <= gxv;
      s1_gyv_r    <= gyv;
      s1_fend_r   <= fend;
      s1_gxi_r    <= gxi;
      s1_gyi_r    <= gyi;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: differences and scaling products
  // ---------------------------------------------------------------------------
  sg2d_pkg::grad_meta_t     dx, dy;
  logic signed [PROD_W-1:0] px, py;

  assign dx.valid = s1_gxv_r;
  assign dx.diff  = {s1_sample_r[SMP_W-1], s1_sample_r} - {s1_left_r[SMP_W-1], s1_left_r};
  assign dx.index = s1_gxi_r;
  assign dy.valid = s1_gyv_r;
  assign dy.diff  = {s1_sample_r[SMP_W-1], s1_sample_r} - {above_r[SMP_W-1], above_r};
  assign dy.index = s1_gyi_r;

  assign px = PROD_W'(dx.diff * $signed({1'b0, inv_step_x_r}));
  assign py = PROD_W'(dy.diff * $signed({1'b0, inv_step_y_r}));

  logic signed [PROD_W-1:0] s2_px_r, s2_py_r;
  logic                     s2_gxv_r, s2_gyv_r, s2_fend_r;
  logic [IDX_W-1:0]         s2_gxi_r, s2_gyi_r;
  logic                     s1_adv;

  assign s1_adv = s1_v_r && s2_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_free) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_px_r   <= px;
      s2_py_r   <= py;
      s2_gxv_r  <= dx.valid;
      s2_gyv_r  <= dy.valid;
      s2_fend_r <= s1_fend_r;
      s2_gxi_r  <= dx.index;
      s2_gyi_r  <= dy.index;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: floor shift (arithmetic shift), saturation, output register
  // ---------------------------------------------------------------------------
  function automatic logic signed [VAL_W-1:0] sat_scale(input logic signed [PROD_W-1:0] p);
    logic signed [Q_W-1:0] q;
    q = Q_W'(p >>> FRAC_W);
    if (!q[Q_W-1] && (q[Q_W-2:VAL_W-1] != '0))
      sat_scale = {1'b0, {(VAL_W-1){1'b1}}};
    else if (q[Q_W-1] && (q[Q_W-2:VAL_W-1] != '1))
      sat_scale = {1'b1, {(VAL_W-1){1'b0}}};
    else
      sat_scale = q[VAL_W-1:0];
  endfunction

  logic                    s2_adv;
  logic signed [VAL_W-1:0] o_gx_value_r, o_gy_value_r;
  logic                    o_gxv_r, o_gyv_r, o_fend_r;
  logic [IDX_W-1:0]        o_gxi_r, o_gyi_r;

  assign s2_adv = s2_v_r && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_free) begin
      out_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      o_gx_value_r <= s2_gxv_r ? sat_scale(s2_px_r) : '0;
      o_gy_value_r <= s2_gyv_r ? sat_scale(s2_py_r) : '0;
      o_gxv_r      <= s2_gxv_r;
      o_gyv_r      <= s2_gyv_r;
      o_fend_r     <= s2_fend_r;
      o_gxi_r      <= s2_gxi_r;
      o_gyi_r      <= s2_gyi_r;
    end
  end

  assign out_ch.valid     = out_v_r;
  assign out_ch.gx_valid  = o_gxv_r;
  assign out_ch.gx_value  = o_gx_value_r;
  assign out_ch.gx_index  = o_gxi_r;
  assign out_ch.gy_valid  = o_gyv_r;
  assign out_ch.gy_value  = o_gy_value_r;
  assign out_ch.gy_index  = o_gyi_r;
  assign out_ch.frame_end = o_fend_r;

endmodule
`default_nettype wire

@@ design/sg2d_checker.sv @@
`default_nettype none
module sg2d_checker (
  input wire logic                               clk,
  input wire logic                               rst_n,
  input wire logic                               out_valid,
  input wire logic                               out_ready,
  input wire logic                               gx_valid,
  input wire logic [sg2d_pkg::VALUE_W-1:0]       gx_value,
  input wire logic [sg2d_pkg::INDEX_W-1:0]       gx_index,
  input wire logic                               gy_valid,
  input wire logic [sg2d_pkg::VALUE_W-1:0]       gy_value,
  input wire logic [sg2d_pkg::INDEX_W-1:0]       gy_index,
  input wire logic                               frame_end
);

  // pipeline empties on reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result item valid after reset");

  // a result with no x difference carries zero value and index
  a_gx_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !gx_valid |-> gx_value == '0 && gx_index == '0)
    else $error("x field not cleared");

  a_gy_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !gy_valid |-> gy_value == '0 && gy_index == '0)
    else $error("y field not cleared");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(gx_value) && $stable(gy_value) &&
      $stable(gx_index) && $stable(gy_index) && $stable(frame_end))
    else $error("result item changed while stalled");

endmodule

bind staggered_gradient_2d_top sg2d_checker u_sg2d_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .gx_valid  (out_ch.gx_valid),
  .gx_value  (out_ch.gx_value),
  .gx_index  (out_ch.gx_index),
  .gy_valid  (out_ch.gy_valid),
  .gy_value  (out_ch.gy_value),
  .gy_index  (out_ch.gy_index),
  .frame_end (out_ch.frame_end)
);
`default_nettype wire

@@ bench/sg2d_grad_checker.sv @@
`timescale 1ns / 100ps
// Watches both channels and the register port, keeps its own copy of the
// gradient state and compares every result item with the oldest prediction.
module sg2d_grad_checker
  import sg2d_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  sg2d_in_if                    in_mon,
  sg2d_out_if                   out_mon,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    checked_count,
  output int                    pending
);

  typedef struct packed {
    logic                      gx_valid;
    logic signed [VALUE_W-1:0] gx_value;
    logic [INDEX_W-1:0]        gx_index;
    logic                      gy_valid;
    logic signed [VALUE_W-1:0] gy_value;
    logic [INDEX_W-1:0]        gy_index;
    logic                      frame_end;
  } grad_result_t;

  localparam longint SAT_HI = 64'sd2147483647;
  localparam longint SAT_LO = -64'sd2147483648;

  // shadow registers and stencil state
  logic [DIM_W-1:0]           width_reg;
  logic [DIM_W-1:0]           height_reg;
  logic [INV_W-1:0]           inv_x;
  logic [INV_W-1:0]           inv_y;
  logic signed [SAMPLE_W-1:0] left_val;
  logic signed [SAMPLE_W-1:0] line_buf [MAX_WIDTH];
  int unsigned                col_cnt;
  int unsigned                row_cnt;

  grad_result_t expected_grads [$];

  function automatic int unsigned eff_dim(input logic [DIM_W-1:0] v, input int unsigned maxv);
    if (v == '0) return 1;
    if (int'(v) > maxv) return maxv;
    return int'(v);
  endfunction

  // floor of (d * inv) / 2^16, saturated to 32 bits
  function automatic logic signed [VALUE_W-1:0] scaled_diff(input longint d,
                                                            input logic [INV_W-1:0] inv);
    longint p;
    longint q;
    p = d * longint'(inv);
    q = p >>> FRAC_W;
    if (q > SAT_HI) q = SAT_HI;
    if (q < SAT_LO) q = SAT_LO;
    return q[VALUE_W-1:0];
  endfunction

  function automatic bit predict_grads(input logic signed [SAMPLE_W-1:0] s,
                                       output grad_result_t r);
    int unsigned w;
    int unsigned h;
    int unsigned col;
    int unsigned row;
    w   = eff_dim(width_reg, MAX_WIDTH);
    h   = eff_dim(height_reg, MAX_HEIGHT);
    col = col_cnt;
    row = row_cnt;
    r   = '0;
    if (col > 0) begin
      r.gx_valid = 1'b1;
      r.gx_value = scaled_diff(longint'(s) - longint'(left_val), inv_x);
      r.gx_index = INDEX_W'((col - 1) + (w - 1) * row);
    end
    if (row > 0) begin
      r.gy_valid = 1'b1;
      r.gy_value = scaled_diff(longint'(s) - longint'(line_buf[col]), inv_y);
      r.gy_index = INDEX_W'(col + w * (row - 1));
    end
    r.frame_end = (col == w - 1) && (row == h - 1);
    left_val      = s;
    line_buf[col] = s;
    if (r.frame_end) begin
      col_cnt = 0;
      row_cnt = 0;
    end else if (col + 1 >= w) begin
      col_cnt = 0;
      row_cnt = row + 1;
    end else begin
      col_cnt = col + 1;
    end
    return r.gx_valid || r.gy_valid || r.frame_end;
  endfunction

  task automatic check_field(input string name, input logic signed [VALUE_W-1:0] want,
                             input logic signed [VALUE_W-1:0] seen);
    if (seen !== want) begin
      $error("%s: expected %0d, got %0d", name, want, seen);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    grad_result_t predicted;
    grad_result_t got;
    grad_result_t want;
    if (!rst_n) begin
      width_reg     = DIM_W'(MAX_WIDTH);
      height_reg    = DIM_W'(MAX_HEIGHT);
      inv_x         = INV_W'(1 << FRAC_W);
      inv_y         = INV_W'(1 << FRAC_W);
      col_cnt       = 0;
      row_cnt       = 0;
      fail_count    = 0;
      checked_count = 0;
      expected_grads.delete();
      pending <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_GRID_WIDTH: begin
            width_reg = cfg_data[DIM_W-1:0];
            col_cnt   = 0;
            row_cnt   = 0;
          end
          REG_GRID_HEIGHT: begin
            height_reg = cfg_data[DIM_W-1:0];
            col_cnt    = 0;
            row_cnt    = 0;
          end
          REG_INV_STEP_X: inv_x = cfg_data[INV_W-1:0];
          REG_INV_STEP_Y: inv_y = cfg_data[INV_W-1:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        if (predict_grads(in_mon.sample, predicted)) begin
          expected_grads.insert(expected_grads.size(), predicted);
        end
      end
      if (out_mon.valid && out_mon.ready) begin
        got.gx_valid  = out_mon.gx_valid;
        got.gx_value  = out_mon.gx_value;
        got.gx_index  = out_mon.gx_index;
        got.gy_valid  = out_mon.gy_valid;
        got.gy_value  = out_mon.gy_value;
        got.gy_index  = out_mon.gy_index;
        got.frame_end = out_mon.frame_end;
        if (expected_grads.size() == 0) begin
          $error("result item with no prediction waiting");
          fail_count++;
        end else begin
          want = expected_grads.pop_front();
          check_field("gx_valid", want.gx_valid, got.gx_valid);
          check_field("gx_value", want.gx_value, got.gx_value);
          check_field("gx_index", want.gx_index, got.gx_index);
          check_field("gy_valid", want.gy_valid, got.gy_valid);
          check_field("gy_value", want.gy_value, got.gy_value);
          check_field("gy_index", want.gy_index, got.gy_index);
          check_field("frame_end", want.frame_end, got.frame_end);
          checked_count++;
        end
      end
      pending <= expected_grads.size();
    end
  end

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 100ps
// Stimulus and verdict for the staggered gradient block. All checking lives in
// the checker instances; this module only drives items, register writes and ready.
module testbench;
  import sg2d_pkg::*;

  // generous limit on the run length
  localparam int CYCLE_LIMIT = 400000;
  localparam int IDLE_PCT    = 17;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int fail_count;
  int checked_count;
  int pending;
  int sent;
  int geometries;
  int cycles;
  bit quiet;   // no idling on either side while set

  sg2d_in_if  in_ch ();
  sg2d_out_if out_ch ();

  staggered_gradient_2d_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  sg2d_grad_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .checked_count (checked_count),
    .pending       (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: stalls about one cycle in six, none during the quiet phase.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Watchdog: a hang or a lost result ends here.
  initial begin
    cycles = 0;
    while (cycles <= CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  // One register write; the trailing wait keeps cfg_we to one NBA per step.
  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Present one sample, with a random gap first, and hold it until taken.
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
    int gaps;
    gaps = 0;
    while (!quiet && $urandom_range(99) < IDLE_PCT) gaps++;
    if (gaps > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gaps) @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.sample <= s;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent++;
  endtask

  // Stop sending and wait for every predicted result, then for the pipeline
  // (stage 1, stage 2, output register) to flush any item that gives no result.
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Dimension word: random junk above the 11 register bits
  function automatic logic [CFG_DATA_W-1:0] dim_word(input int unsigned v);
    logic [CFG_DATA_W-1:0] word;
    word = CFG_DATA_W'($urandom);
    word[DIM_W-1:0] = v[DIM_W-1:0];
    return word;
  endfunction

  task automatic set_geometry(input int unsigned w, input int unsigned h);
    if ($urandom_range(1) == 1) begin
      write_reg(REG_GRID_WIDTH, dim_word(w));
      write_reg(REG_GRID_HEIGHT, dim_word(h));
    end else begin
      write_reg(REG_GRID_HEIGHT, dim_word(h));
      write_reg(REG_GRID_WIDTH, dim_word(w));
    end
    geometries++;
  endtask

  // Mostly small grids; 0 must behave as 1
  function automatic int unsigned pick_dim();
    case ($urandom_range(9))
      0:       return 0;
      1:       return 1;
      2:       return 2;
      3, 4, 5: return $urandom_range(3, 8);
      6, 7:    return $urandom_range(9, 24);
      8:       return $urandom_range(25, 64);
      default: return $urandom_range(2, 5);
    endcase
  endfunction

  function automatic logic [INV_W-1:0] pick_inv();
    case ($urandom_range(5))
      0:       return '0;
      1:       return '1;
      2:       return INV_W'(1 << FRAC_W);
      3:       return INV_W'($urandom_range(0, 24'h03FFFF));
      default: return INV_W'($urandom);
    endcase
  endfunction

  // Extremes for saturation, small values for the floor rounding near zero
  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(9))
      0:          return {1'b1, {(SAMPLE_W-1){1'b0}}};
      1:          return {1'b0, {(SAMPLE_W-1){1'b1}}};
      2, 3, 4:    return SAMPLE_W'($urandom_range(0, 600)) - SAMPLE_W'(300);
      default:    return SAMPLE_W'($urandom);
    endcase
  endfunction

  initial begin
    int n;
    int phase;
    int random_sent;
    logic signed [SAMPLE_W-1:0] s_max;
    logic signed [SAMPLE_W-1:0] s_min;
    s_max = {1'b0, {(SAMPLE_W-1){1'b1}}};
    s_min = {1'b1, {(SAMPLE_W-1){1'b0}}};
    sent       = 0;
    geometries = 0;
    quiet      = 1'b0;
    rst_n        <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_index    <= REG_GRID_WIDTH;
    cfg_data     <= '0;
    in_ch.valid  <= 1'b0;
    in_ch.sample <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed part ---
    // reset geometry and unit reciprocals: first row of a 1024-wide frame
    send_sample(s_max);
    send_sample(s_min);
    send_sample('0);
    send_sample('1);
    settle();

    // single-sample frame, width written as 0 with junk in the upper bits
    write_reg(REG_GRID_WIDTH, 24'hFFF800);
    write_reg(REG_GRID_HEIGHT, 24'h000001);
    geometries++;
    send_sample(s_max);
    send_sample(s_min);
    settle();

    // 3x2 with full-scale reciprocals: saturation both ways, then a frame
    // of small values for negative floor rounding
    set_geometry(3, 2);
    write_reg(REG_INV_STEP_X, '1);
    write_reg(REG_INV_STEP_Y, '1);
    send_sample(s_max);
    send_sample(s_min);
    send_sample(s_max);
    send_sample(s_min);
    send_sample(s_max);
    send_sample(s_min);
    send_sample(SAMPLE_W'(-1));
    send_sample(SAMPLE_W'(1));
    send_sample(SAMPLE_W'(-3));
    send_sample(SAMPLE_W'(2));
    send_sample(SAMPLE_W'(0));
    send_sample(SAMPLE_W'(5));

    // --- random part: small grids, a fresh setting per phase ---
    phase       = 0;
    random_sent = 0;
    while (random_sent < 200) begin
      settle();
      quiet = (phase == 2);
      set_geometry(pick_dim(), pick_dim());
      write_reg(REG_INV_STEP_X, pick_inv());
      write_reg(REG_INV_STEP_Y, pick_inv());
      n = $urandom_range(20, 60);
      for (int i = 0; i < n; i++) begin
        // drain mid-frame and change a reciprocal; the frame must carry on
        if (i == n / 2 && (phase == 0 || $urandom_range(1) == 1)) begin
          settle();
          if ($urandom_range(1) == 1) write_reg(REG_INV_STEP_X, pick_inv());
          else write_reg(REG_INV_STEP_Y, pick_inv());
        end
        send_sample(pick_sample());
      end
      random_sent += n;
      phase++;
    end
    quiet = 1'b0;

    // --- widest row: 2047 clamps to the maximum, into the second row ---
    settle();
    set_geometry(2047, 2);
    write_reg(REG_INV_STEP_X, pick_inv());
    write_reg(REG_INV_STEP_Y, pick_inv());
    repeat (1028) send_sample(pick_sample());

    settle();
    $display("sent %0d samples over %0d grid settings; %0d result items compared",
             sent, geometries, checked_count);
    $display("covered reset geometry, clamped sizes, saturation and mid-frame reciprocal changes");
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/sg2d_pkg.sv
design/sg2d_if.sv
design/staggered_gradient_2d_top.sv
design/sg2d_checker.sv
bench/sg2d_grad_checker.sv
bench/testbench.sv
